FILE: hdl/assert_macros.svh
// Assertion macros shared by the reverb RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hdl/scar_pkg.sv
// Package: widths, line layout, register codes and arithmetic helpers of the reverb.
package scar_pkg;
	localparam int SB = 48;
	localparam int NUM_COMBS = 8;
	localparam int NUM_AP = 4;
	localparam int COMB_DEPTH = 2 * 11024;
	localparam int AP_DEPTH = 2 * 1563;
	localparam int CA_W = 15;
	localparam int AA_W = 12;
	localparam int CP_W = 11;
	localparam int AP_W = 10;

	typedef logic signed [SB-1:0] st_t;
	typedef logic [17:0] gain_t;

	typedef enum logic [2:0] {
		REG_INPUT_GAIN = 3'd0,
		REG_WET_GAIN = 3'd1,
		REG_DRY_GAIN = 3'd2,
		REG_COMB_FB = 3'd3,
		REG_COMB_DAMP = 3'd4,
		REG_COMB_UNDAMP = 3'd5,
		REG_AP_FB = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_CLEAR, ST_CRD, ST_CM1, ST_CM2, ST_CWR,
		ST_ARD, ST_AM1, ST_AWR, ST_OM1, ST_OUT, ST_DONE
	} state_t;

	function automatic logic [CP_W-1:0] comb_len(input logic [2:0] i);
		case (i)
			3'd0: comb_len = 11'd1116;
			3'd1: comb_len = 11'd1188;
			3'd2: comb_len = 11'd1277;
			3'd3: comb_len = 11'd1356;
			3'd4: comb_len = 11'd1422;
			3'd5: comb_len = 11'd1491;
			3'd6: comb_len = 11'd1557;
			default: comb_len = 11'd1617;
		endcase
	endfunction

	function automatic logic [CA_W-1:0] comb_base(input logic [2:0] i);
		case (i)
			3'd0: comb_base = 15'd0;
			3'd1: comb_base = 15'd1116;
			3'd2: comb_base = 15'd2304;
			3'd3: comb_base = 15'd3581;
			3'd4: comb_base = 15'd4937;
			3'd5: comb_base = 15'd6359;
			3'd6: comb_base = 15'd7850;
			default: comb_base = 15'd9407;
		endcase
	endfunction

	function automatic logic [AP_W-1:0] ap_len(input logic [1:0] i);
		case (i)
			2'd0: ap_len = 10'd225;
			2'd1: ap_len = 10'd341;
			2'd2: ap_len = 10'd441;
			default: ap_len = 10'd556;
		endcase
	endfunction

	function automatic logic [AA_W-1:0] ap_base(input logic [1:0] i);
		case (i)
			2'd0: ap_base = 12'd0;
			2'd1: ap_base = 12'd225;
			2'd2: ap_base = 12'd566;
			default: ap_base = 12'd1007;
		endcase
	endfunction

	function automatic st_t sat66(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF_FFFF) sat66 = {1'b0, {(SB-1){1'b1}}};
		else if (v < -66'sh0_8000_0000_0000) sat66 = {1'b1, {(SB-1){1'b0}}};
		else sat66 = v[SB-1:0];
	endfunction

	function automatic st_t sadd(input st_t a, input st_t b);
		sadd = sat66(66'(a) + 66'(b));
	endfunction

	function automatic st_t ssub(input st_t a, input st_t b);
		ssub = sat66(66'(a) - 66'(b));
	endfunction

	// magnitude product (<=48x18) rounded by half away from zero, signed back
	function automatic st_t rfin(input logic neg, input logic [65:0] p);
		logic [65:0] r;
		r = (p + 66'd32768) >> 16;
		if (!neg) rfin = (r > 66'h7FFF_FFFF_FFFF) ? {1'b0, {(SB-1){1'b1}}} : r[SB-1:0];
		else if (r >= 66'h8000_0000_0000) rfin = {1'b1, {(SB-1){1'b0}}};
		else rfin = SB'(-r[SB-1:0]);
	endfunction
endpackage

FILE: hdl/scar_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface scar_in_if (input logic clk);
	logic valid;
	logic ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	modport source (output valid, left_sample, right_sample, input ready);
	modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface scar_out_if (input logic clk);
	logic valid;
	logic ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface scar_cfg_if (input logic clk);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [17:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/stereo_comb_allpass_reverb_q16.sv
// Top level: two-channel comb/allpass reverb built around shared delay memories.
//  channel | dir | payload                         | handshake
//  cfg     | in  | index[2:0], data[17:0]          | valid/ready, always ready
//  in      | in  | left_sample, right_sample (s16) | valid/ready
//  out     | out | left_out, right_out (s16)       | valid/ready, held until taken
// An item runs through one comb memory port and one multiplier, stepped by a sequencer
// per tap, left channel then right. Product steps use one 48x18 multiply.
// After reset a clear pass over all 22048 comb entries zeroes the comb memory (allpass
// memory in the same pass); no item is accepted meanwhile. Results sit in an output register;
// a result still waiting there holds the sequencer at the end of the next item.
`include "assert_macros.svh"
module stereo_comb_allpass_reverb_q16 (
	input logic clk,
	input logic arst_n,
	scar_cfg_if.sink cfg,
	scar_in_if.sink in_ch,
	scar_out_if.source out_ch
);
	import scar_pkg::*;

	state_t state_q, state_d;
	logic [17:0] regs_q [7];
	st_t comb_mem [COMB_DEPTH];
	st_t ap_mem [AP_DEPTH];
	st_t comb_rd_q, ap_rd_q;
	logic [CA_W-1:0] clr_q;
	logic [CP_W-1:0] cpos_q [2*NUM_COMBS];
	logic [AP_W-1:0] apos_q [2*NUM_AP];
	st_t cfilt_q [2*NUM_COMBS];
	logic ch_q;
	logic [2:0] ci_q;
	logic [1:0] ai_q;
	logic signed [15:0] smp_q [2];
	st_t inp_q, acc_q, f_q, t_q;
	logic signed [15:0] res_q [2];
	logic signed [15:0] obuf_q [2];
	logic ov_q;

	logic [3:0] cidx;
	logic [2:0] aidx;
	logic [CA_W-1:0] caddr;
	logic [AA_W-1:0] aaddr;
	logic c_we, a_we;
	st_t c_wd, a_wd;
	logic signed [15:0] cur_s;
	logic neg;
	logic [SB-1:0] mag;
	logic [17:0] mg;
	logic [65:0] prod;
	st_t mres, in_s, dry, fin;
	logic [SB-1:0] fm;
	logic [SB-1:0] fr;
	logic signed [15:0] osat;
	logic last_c, last_a;
	logic obuf_load;

	assign cidx = {ch_q, ci_q};
	assign aidx = {ch_q, ai_q};
	assign cur_s = smp_q[ch_q];
	assign caddr = (state_q == ST_CLEAR) ? clr_q :
		CA_W'(comb_base(ci_q)) + (ch_q ? CA_W'(11024) : CA_W'(0)) + CA_W'(cpos_q[cidx]);
	assign aaddr = (state_q == ST_CLEAR) ? clr_q[AA_W-1:0] :
		ap_base(ai_q) + (ch_q ? AA_W'(1563) : AA_W'(0)) + AA_W'(apos_q[aidx]);
	assign last_c = (ci_q == 3'(NUM_COMBS - 1));
	assign last_a = (ai_q == 2'(NUM_AP - 1));
	assign obuf_load = (state_q == ST_DONE) && (!ov_q || out_ch.ready);

	// operand select for the shared multiplier
	always_comb begin
		st_t x;
		logic [17:0] g;
		x = '0;
		g = '0;
		case (state_q)
			ST_CM1: begin x = comb_rd_q; g = regs_q[REG_COMB_UNDAMP]; end
			ST_CM2: begin x = cfilt_q[cidx]; g = regs_q[REG_COMB_DAMP]; end
			ST_CWR: begin x = f_q; g = regs_q[REG_COMB_FB]; end
			ST_AM1: begin x = ap_rd_q; g = regs_q[REG_AP_FB]; end
			ST_OM1: begin x = acc_q; g = regs_q[REG_WET_GAIN]; end
			default: begin x = '0; g = '0; end
		endcase
		neg = x[SB-1];
		mag = neg ? SB'(-x) : x;
		mg = g;
	end
	assign prod = 66'(mag) * 66'(mg);
	assign mres = rfin(neg, prod);
	assign in_s = SB'($signed(34'(cur_s)) * $signed({16'd0, regs_q[REG_INPUT_GAIN]}));
	assign dry = SB'($signed(35'(cur_s)) * $signed({17'd0, regs_q[REG_DRY_GAIN]}));
	assign fin = sadd(dry, t_q);
	assign fm = fin[SB-1] ? SB'(-fin) : fin;
	assign fr = (fm + SB'(32768)) >> 16;
	always_comb begin
		if (fin[SB-1]) osat = (fr > SB'(32768)) ? -16'sd32768 : 16'(-fr);
		else osat = (fr > SB'(32767)) ? 16'sd32767 : fr[15:0];
	end

	assign c_we = (state_q == ST_CLEAR) || (state_q == ST_CWR);
	assign c_wd = (state_q == ST_CLEAR) ? '0 : sadd(inp_q, mres);
	assign a_we = (state_q == ST_CLEAR && clr_q < CA_W'(AP_DEPTH)) || (state_q == ST_AWR);
	assign a_wd = (state_q == ST_CLEAR) ? '0 : t_q;

	always_ff @(posedge clk) begin
		if (c_we) comb_mem[caddr] <= c_wd;
		comb_rd_q <= comb_mem[caddr];
		if (a_we) ap_mem[aaddr] <= a_wd;
		ap_rd_q <= ap_mem[aaddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_CLEAR;
			ST_CLEAR: if (clr_q == CA_W'(COMB_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_ch.valid) state_d = ST_CRD;
			ST_CRD: state_d = ST_CM1;
			ST_CM1: state_d = ST_CM2;
			ST_CM2: state_d = ST_CWR;
			ST_CWR: state_d = last_c ? ST_ARD : ST_CRD;
			ST_ARD: state_d = ST_AM1;
			ST_AM1: state_d = ST_AWR;
			ST_AWR: state_d = last_a ? ST_OM1 : ST_ARD;
			ST_OM1: state_d = ST_OUT;
			ST_OUT: state_d = ch_q ? ST_DONE : ST_CRD;
			ST_DONE: if (!ov_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		out_ch.valid = ov_q;
		out_ch.left_out = obuf_q[0];
		out_ch.right_out = obuf_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			ov_q <= 1'b0;
			ch_q <= 1'b0;
			ci_q <= '0;
			ai_q <= '0;
			regs_q[0] <= 18'd983;
			regs_q[1] <= 18'd52429;
			regs_q[2] <= 18'd56361;
			regs_q[3] <= 18'd55706;
			regs_q[4] <= 18'd20972;
			regs_q[5] <= 18'd44564;
			regs_q[6] <= 18'd32768;
			for (int i = 0; i < 2*NUM_COMBS; i++) begin
				cpos_q[i] <= '0;
				cfilt_q[i] <= '0;
			end
			for (int i = 0; i < 2*NUM_AP; i++) apos_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_WET_GAIN, REG_DRY_GAIN: regs_q[cfg.index] <= cfg.data;
					REG_INPUT_GAIN, REG_COMB_FB, REG_COMB_DAMP, REG_COMB_UNDAMP, REG_AP_FB:
						regs_q[cfg.index] <= {1'b0, cfg.data[16:0]};
					default: ;
				endcase
			end
			if (obuf_load) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					ch_q <= 1'b0;
					ci_q <= '0;
					ai_q <= '0;
				end
				ST_CWR: begin
					cfilt_q[cidx] <= f_q;
					cpos_q[cidx] <= (cpos_q[cidx] == comb_len(ci_q) - 1'b1) ? '0
						: cpos_q[cidx] + 1'b1;
					ci_q <= ci_q + 1'b1;
				end
				ST_AWR: begin
					apos_q[aidx] <= (apos_q[aidx] == ap_len(ai_q) - 1'b1) ? '0
						: apos_q[aidx] + 1'b1;
					ai_q <= ai_q + 1'b1;
				end
				ST_OUT: begin
					ch_q <= ~ch_q;
					ci_q <= '0;
					ai_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				smp_q[0] <= in_ch.left_sample;
				smp_q[1] <= in_ch.right_sample;
				acc_q <= '0;
			end
			ST_CRD: inp_q <= in_s;
			ST_CM1: begin
				t_q <= mres;
				acc_q <= sadd(acc_q, comb_rd_q);
			end
			ST_CM2: f_q <= sadd(t_q, mres);
			ST_AM1: begin
				t_q <= sadd(acc_q, mres);
				acc_q <= ssub(ap_rd_q, acc_q);
			end
			ST_OM1: t_q <= mres;
			ST_OUT: begin
				res_q[ch_q] <= osat;
				acc_q <= '0;
			end
			ST_DONE: begin
				if (obuf_load) begin
					obuf_q[0] <= res_q[0];
					obuf_q[1] <= res_q[1];
				end
			end
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_no_accept_clear, clk, arst_n, state_q == ST_CLEAR, !in_ch.ready, "accept during clear")
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ch.ready, state_q == ST_IDLE, "ready outside idle")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
	`ASSERT_NEXT(a_accept_run, clk, arst_n, in_ch.valid && in_ch.ready, state_q == ST_CRD, "item not started")
endmodule

FILE: tb/stereo_comb_allpass_reverb_q16_tb.sv
// Self-checking testbench of the stereo comb/allpass reverb: queued frames, Q16 network predictor.
module stereo_comb_allpass_reverb_q16_tb;
	import scar_pkg::*;

	localparam int LIMIT = 8000000;
	localparam int TAIL = 400;
	localparam int CLEN [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int ALEN [4] = '{225, 341, 441, 556};
	localparam logic signed [67:0] SMAXV = 68'sh7FFF_FFFF_FFFF;
	localparam logic signed [67:0] SMINV = -68'sh8000_0000_0000;

	typedef logic signed [47:0] q48_t;
	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] r;
	} frame_t;

	logic clk;
	logic arst_n;

	scar_cfg_if cfg (clk);
	scar_in_if in_ch (clk);
	scar_out_if out_ch (clk);

	stereo_comb_allpass_reverb_q16 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	frame_t pending_frames[$];
	frame_t expected_frames[$];
	frame_t held_frame;
	int errors;
	int cycles;
	int out_hold;
	bit calm;

	logic [17:0] gains [7];
	q48_t comb_line [2][8][1617];
	q48_t comb_store [2][8];
	int comb_at [2][8];
	q48_t ap_line [2][4][556];
	int ap_at [2][4];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic q48_t clamp48(input logic signed [67:0] v);
		if (v > SMAXV) return q48_t'(SMAXV);
		if (v < SMINV) return q48_t'(SMINV);
		return v[47:0];
	endfunction

	function automatic q48_t add48(input q48_t a, input q48_t b);
		return clamp48(68'(a) + 68'(b));
	endfunction

	function automatic q48_t q16_mul(input q48_t x, input logic [17:0] g);
		logic signed [67:0] xs;
		logic [67:0] p;
		xs = x;
		p = (x < 0) ? 68'(-xs) : 68'(xs);
		p = (p * 68'(g) + 68'd32768) >> 16;
		return clamp48((x < 0) ? -$signed(p) : $signed(p));
	endfunction

	function automatic logic signed [15:0] reverb_channel(input int ch,
			input logic signed [15:0] smp);
		q48_t drive, acc, o, f, b, res;
		logic [47:0] m;
		drive = clamp48(68'(smp) * $signed({1'b0, gains[REG_INPUT_GAIN]}));
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			o = comb_line[ch][i][comb_at[ch][i]];
			f = add48(q16_mul(o, gains[REG_COMB_UNDAMP]),
				q16_mul(comb_store[ch][i], gains[REG_COMB_DAMP]));
			comb_store[ch][i] = f;
			comb_line[ch][i][comb_at[ch][i]] = add48(drive, q16_mul(f, gains[REG_COMB_FB]));
			comb_at[ch][i] = (comb_at[ch][i] + 1 >= CLEN[i]) ? 0 : comb_at[ch][i] + 1;
			acc = add48(acc, o);
		end
		for (int i = 0; i < 4; i++) begin
			b = ap_line[ch][i][ap_at[ch][i]];
			o = clamp48(68'(b) - 68'(acc));
			ap_line[ch][i][ap_at[ch][i]] = add48(acc, q16_mul(b, gains[REG_AP_FB]));
			ap_at[ch][i] = (ap_at[ch][i] + 1 >= ALEN[i]) ? 0 : ap_at[ch][i] + 1;
			acc = o;
		end
		res = add48(clamp48(68'(smp) * $signed({1'b0, gains[REG_DRY_GAIN]})),
			q16_mul(acc, gains[REG_WET_GAIN]));
		m = (res < 0) ? -res : res;
		m = (m + 48'd32768) >> 16;
		if (res < 0) return (m > 48'd32768) ? -16'sd32768 : 16'(-$signed(m[16:0]));
		return (m > 48'd32767) ? 16'sd32767 : m[15:0];
	endfunction

	function automatic logic [17:0] gain_mask(input reg_idx_t idx, input logic [17:0] d);
		if (idx == REG_WET_GAIN || idx == REG_DRY_GAIN) return d;
		return {1'b0, d[16:0]};
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2, 3: return $signed(16'($urandom_range(0, 511)) - 16'sd256);
			default: return $signed(16'($urandom));
		endcase
	endfunction

	task automatic cfg_write(input reg_idx_t idx, input logic [17:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		gains[idx] = gain_mask(idx, d);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic push_frame(input logic signed [15:0] l, input logic signed [15:0] r);
		frame_t fr;
		fr.l = l;
		fr.r = r;
		pending_frames.push_back(fr);
	endtask

	task automatic push_random(input int n);
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 3) == 0) begin
				// impulse then silence, so the tail of the network is exercised
				push_frame(pick_sample(), pick_sample());
				repeat ($urandom_range(5, 40)) push_frame('0, '0);
				k += 20;
			end else begin
				push_frame(pick_sample(), pick_sample());
				k++;
			end
		end
	endtask

	task automatic drain();
		wait (pending_frames.size() == 0 && !in_ch.valid && expected_frames.size() == 0);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_all(input logic [17:0] v [7]);
		for (int i = 0; i < 7; i++) cfg_write(reg_idx_t'(i), v[i]);
	endtask

	// input driver
	int in_gap;
	bit in_taken;
	always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.left_sample <= '0;
			in_ch.right_sample <= '0;
			in_gap <= 0;
		end else if (in_ch.valid && !in_taken) begin
		end else if (in_gap > 0) begin
			in_ch.valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_frames.size() > 0) begin
			held_frame = pending_frames.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.left_sample <= held_frame.l;
			in_ch.right_sample <= held_frame.r;
			if (calm) in_gap <= 0;
			else case ($urandom_range(0, 9))
				0, 1, 2: in_gap <= $urandom_range(1, 4);
				3: in_gap <= $urandom_range(60, 300);
				default: in_gap <= 0;
			endcase
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// result receiver; out_hold is a long hold-off requested by the sequence
	int out_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap <= 0;
		end else if (out_hold > 0) begin
			out_ch.ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else if (out_gap > 0) begin
			out_ch.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if (calm) out_gap <= 0;
			else case ($urandom_range(0, 9))
				0, 1: out_gap <= $urandom_range(1, 5);
				2: out_gap <= $urandom_range(40, 250);
				default: out_gap <= 0;
			endcase
		end
	end

	always @(posedge clk) begin
		frame_t fr;
		frame_t want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			fr.l = reverb_channel(0, in_ch.left_sample);
			fr.r = reverb_channel(1, in_ch.right_sample);
			expected_frames.push_back(fr);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_frames.size() == 0) begin
				$error("unexpected item: left_out %0d right_out %0d",
					out_ch.left_out, out_ch.right_out);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				if (out_ch.left_out !== want.l) begin
					$error("left_out expected %0d actual %0d", want.l, out_ch.left_out);
					errors++;
				end
				if (out_ch.right_out !== want.r) begin
					$error("right_out expected %0d actual %0d", want.r, out_ch.right_out);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [17:0] v [7];
		errors = 0;
		cycles = 0;
		out_hold = 0;
		calm = 1'b0;
		gains = '{18'd983, 18'd52429, 18'd56361, 18'd55706, 18'd20972, 18'd44564, 18'd32768};
		for (int c = 0; c < 2; c++) begin
			for (int i = 0; i < 8; i++) begin
				comb_store[c][i] = '0;
				comb_at[c][i] = 0;
				for (int j = 0; j < 1617; j++) comb_line[c][i][j] = '0;
			end
			for (int i = 0; i < 4; i++) begin
				ap_at[c][i] = 0;
				for (int j = 0; j < 556; j++) ap_line[c][i][j] = '0;
			end
		end
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset gains, directed extremes
		calm = 1'b1;
		push_frame(16'sd32767, -16'sd32768);
		push_frame(-16'sd32768, 16'sd32767);
		push_frame('0, '0);
		push_frame(16'sd1, -16'sd1);
		push_frame(-16'sd1, 16'sd1);
		for (int i = 0; i < 10; i++) push_frame(16'sd32767, 16'sd32767);
		for (int i = 0; i < 8; i++) push_frame((i % 2) ? -16'sd32768 : 16'sd32767, 16'h5555);
		drain();

		// high gains, wet gain at its top, state runs into saturation
		calm = 1'b0;
		v = '{18'd65536, 18'd262143, 18'd131072, 18'd65536, 18'd65536, 18'd65536, 18'd65536};
		write_all(v);
		for (int i = 0; i < 60; i++) push_frame(16'sd32767, -16'sd32768);
		push_random(300);
		drain();

		// all gains zero
		v = '{default: 18'd0};
		write_all(v);
		push_random(150);
		drain();

		// reset values again, with a long receiver hold-off while the sender keeps offering
		v = '{18'd983, 18'd52429, 18'd56361, 18'd55706, 18'd20972, 18'd44564, 18'd32768};
		write_all(v);
		push_random(300);
		@(posedge clk);
		out_hold = 3000;
		drain();

		// random gains, full 18-bit data in the later phases so out-of-range bits are masked
		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 1);
			for (int i = 0; i < 7; i++) v[i] = (ph < 2) ? 18'($urandom_range(0, 65536))
				: 18'($urandom);
			write_all(v);
			push_random(300);
			drain();
		end

		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
